### hdl/adaptive_rice_pixel_encoder_defines.svh
// assertion macros for the adaptive rice pixel encoder
`ifndef ADAPTIVE_RICE_PIXEL_ENCODER_DEFINES_SVH
`define ADAPTIVE_RICE_PIXEL_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on every rising edge outside reset
`define ARPE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("arpe assertion failed");
// next-cycle implication, checked on every rising edge outside reset
`define ARPE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("arpe assertion failed");
`else
`define ARPE_ASSERT_IMPL(label, ante, cons)
`define ARPE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hdl/arpe_pkg.sv
// shared types and constants of the adaptive rice pixel encoder
package arpe_pkg;

  localparam int CFG_W       = 13;  // image width register
  localparam int ERR_W       = 11;  // running error estimate
  localparam int ERR_MAX     = 2**ERR_W - 1;
  localparam int WORD_W      = 64;  // packed output word
  localparam int FREE_W      = 7;   // free bit count, 1..64
  localparam int ZERO_W      = 11;  // unary zero run of one code
  localparam int TAIL_W      = 12;  // stop bit plus up to 11 low bits
  localparam int TLEN_W      = 4;   // tail length, 1..12
  localparam int K_W         = 4;   // rice parameter, 0..11
  localparam int TOT_W       = 12;  // bits still owed by one code
  localparam int NEEE_OFFSET = 3;   // north-east-east-east error tap

  // one code handed from the predictor to the packer
  typedef struct packed {
    logic [ZERO_W-1:0] zeros;
    logic [TAIL_W-1:0] tail_val;
    logic [TLEN_W-1:0] tail_len;
    logic              last;
  } arpe_job_t;

endpackage

### hdl/adaptive_rice_pixel_encoder.sv
// Adaptive Rice pixel encoder: lossless raster coder with median prediction.
// Input channel: one pixel per transaction (in_valid / in_stall), raster order,
// in_last_pixel marks the final pixel of an image and flushes the open word.
// Output channel: 64-bit packed words (out_valid / out_stall), first code bit
// in the MSB; out_last_of_run marks the final word caused by a pixel and
// out_end_of_stream the flushed final word of an image.
// Configuration: cfg_wr_en writes cfg_image_width (clamped to 1..MAX_WIDTH);
// write it only while no transaction is in flight.
// Pacing: each pixel takes a memory read, then a code and write-back step, set by
// the read-modify-write of the previous-row memories; a new pixel is taken only
// once the last has left the code stage. The packer adds a step for each word a
// code fills, except a word that the code's last bits end exactly, and one for
// the flush; in that time the next pixel waits in the code stage.
// Path: with the receiver free, the first word a pixel completes passes the code
// stage, a packing step and the output register; each later packing step of that
// pixel (another word, the rest of the tail, the flush) adds a further step.
// Reset: column, neighbours and bit cache clear at once; the row memories are
// not swept, a fill count makes unwritten columns read as zero.
// A stalled receiver holds the output register and the packer at steps that emit
// a word; in_stall rises once the next pixel reaches the code stage.
`include "adaptive_rice_pixel_encoder_defines.svh"

module adaptive_rice_pixel_encoder import arpe_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_W-1:0]      cfg_image_width,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIXEL_BITS-1:0] in_pixel_value,
  input  logic                  in_last_pixel,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [WORD_W-1:0]     out_stream_word,
  output logic                  out_last_of_run,
  output logic                  out_end_of_stream
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CODE = 2'b10
  } enc_state_t;

  enc_state_t            state_r, state_nxt;
  logic [CFG_W-1:0]      width_r;
  logic [COL_W-1:0]      col_r;
  logic [PIXEL_BITS-1:0] west_r;
  logic [PIXEL_BITS-1:0] nw_r;
  logic [ERR_W-1:0]      werr_r;
  logic                  first_row_r;
  logic [PIXEL_BITS-1:0] pix_r;
  logic                  last_r;

  logic                  in_acc;
  logic                  commit;
  logic                  end_row;
  logic [WID_W-1:0]      width_eff;
  logic [WID_W-1:0]      col_inc;
  logic [PIXEL_BITS-1:0] north_raw;
  logic [ERR_W-1:0]      neee_raw;
  logic [PIXEL_BITS-1:0] north;
  logic [ERR_W-1:0]      err_new;
  arpe_job_t             job;
  logic                  job_ready;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign commit   = (state_r == ST_CODE) && job_ready;

  // effective row width
  always_comb begin
    if (width_r == '0) begin
      width_eff = WID_W'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      width_eff = WID_W'(MAX_WIDTH);
    end else begin
      width_eff = WID_W'(width_r);
    end
  end

  assign col_inc = WID_W'(col_r) + WID_W'(1);
  assign end_row = (col_inc >= width_eff) || last_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= CFG_W'(4096);
    end else if (cfg_wr_en) begin
      width_r <= cfg_image_width;
    end
  end

  // sequencer: read stage then code stage
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_CODE;
        end
      end
      ST_CODE: begin
        if (job_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // sequencer state and row position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      west_r      <= '0;
      nw_r        <= '0;
      werr_r      <= '0;
      first_row_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        if (end_row) begin
          col_r       <= '0;
          west_r      <= '0;
          nw_r        <= '0;
          werr_r      <= '0;
          first_row_r <= last_r;
        end else begin
          col_r  <= COL_W'(col_inc);
          west_r <= pix_r;
          nw_r   <= north;
          werr_r <= err_new;
        end
      end
    end
  end

  // accepted pixel
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_r  <= in_pixel_value;
      last_r <= in_last_pixel;
    end
  end

  arpe_row_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_en       (in_acc),
    .rd_col      (col_r),
    .wr_en       (commit),
    .wr_col      (col_r),
    .wr_pixel    (pix_r),
    .wr_error    (err_new),
    .north_pixel (north_raw),
    .neee_error  (neee_raw)
  );

  arpe_predictor #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_pred (
    .col        (col_r),
    .width      (width_eff),
    .first_row  (first_row_r),
    .last       (last_r),
    .pixel      (pix_r),
    .north_raw  (north_raw),
    .neee_raw   (neee_raw),
    .west_pixel (west_r),
    .nw_pixel   (nw_r),
    .west_error (werr_r),
    .north      (north),
    .err_new    (err_new),
    .job        (job)
  );

  arpe_packer u_pack (
    .clk               (clk),
    .rst_n             (rst_n),
    .job_valid         (state_r == ST_CODE),
    .job               (job),
    .job_ready         (job_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_stream_word   (out_stream_word),
    .out_last_of_run   (out_last_of_run),
    .out_end_of_stream (out_end_of_stream)
  );

  // checks
  `ARPE_ASSERT_NEXT(a_accept_to_code, in_valid && !in_stall, state_r == ST_CODE)
  `ARPE_ASSERT_IMPL(a_eos_ends_run, out_valid && out_end_of_stream, out_last_of_run)
  `ARPE_ASSERT_NEXT(a_row_end_clears, commit && end_row, col_r == '0 && werr_r == '0 && west_r == '0)

endmodule

### hdl/arpe_row_store.sv
// previous-row pixel and error memories with fill count
module arpe_row_store import arpe_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]       rd_col,
  input  logic                               wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]       wr_col,
  input  logic [PIXEL_BITS-1:0]              wr_pixel,
  input  logic [ERR_W-1:0]                   wr_error,
  output logic [PIXEL_BITS-1:0]              north_pixel,
  output logic [ERR_W-1:0]                   neee_error
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int SUM_W = WID_W + 1;

  logic [PIXEL_BITS-1:0] pix_mem_r [MAX_WIDTH];
  logic [ERR_W-1:0]      err_mem_r [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] pix_rd_r;
  logic [ERR_W-1:0]      err_rd_r;
  logic                  n_ok_r;
  logic                  e_ok_r;
  logic [WID_W-1:0]      fill_r;
  logic [COL_W-1:0]      neee_col;
  logic [SUM_W-1:0]      neee_sum;

  // columns are written in order from zero, so all below fill_r are written
  assign neee_sum = SUM_W'(rd_col) + SUM_W'(NEEE_OFFSET);
  assign neee_col = rd_col + COL_W'(NEEE_OFFSET);

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pix_mem_r[wr_col] <= wr_pixel;
      err_mem_r[wr_col] <= wr_error;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      pix_rd_r <= pix_mem_r[rd_col];
      err_rd_r <= err_mem_r[neee_col];
    end
  end

  // fill count and read validity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      n_ok_r <= 1'b0;
      e_ok_r <= 1'b0;
    end else begin
      if (wr_en && (WID_W'(wr_col) >= fill_r)) begin
        fill_r <= WID_W'(wr_col) + WID_W'(1);
      end
      if (rd_en) begin
        n_ok_r <= WID_W'(rd_col) < fill_r;
        e_ok_r <= neee_sum < SUM_W'(fill_r);
      end
    end
  end

  // never-written entries read as zero
  assign north_pixel = n_ok_r ? pix_rd_r : '0;
  assign neee_error  = e_ok_r ? err_rd_r : '0;

endmodule

### hdl/arpe_predictor.sv
// median predictor, zigzag map, rice parameter and error update
module arpe_predictor import arpe_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 10
) (
  input  logic [$clog2(MAX_WIDTH)-1:0]   col,
  input  logic [$clog2(MAX_WIDTH+1)-1:0] width,
  input  logic                           first_row,
  input  logic                           last,
  input  logic [PIXEL_BITS-1:0]          pixel,
  input  logic [PIXEL_BITS-1:0]          north_raw,
  input  logic [ERR_W-1:0]               neee_raw,
  input  logic [PIXEL_BITS-1:0]          west_pixel,
  input  logic [PIXEL_BITS-1:0]          nw_pixel,
  input  logic [ERR_W-1:0]               west_error,
  output logic [PIXEL_BITS-1:0]          north,
  output logic [ERR_W-1:0]               err_new,
  output arpe_job_t                      job
);

  localparam int WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int SUM_W  = WID_W + 1;
  localparam int PRED_W = PIXEL_BITS + 2;
  localparam int SYM_W  = PIXEL_BITS + 1;
  localparam int ESUM_W = ERR_W + 3;

  logic [PIXEL_BITS-1:0]    nw;
  logic [PIXEL_BITS-1:0]    lo;
  logic [PIXEL_BITS-1:0]    hi;
  logic [ERR_W-1:0]         eneee;
  logic signed [PRED_W-1:0] pred_raw;
  logic signed [PRED_W-1:0] pred;
  logic signed [PRED_W-1:0] res;
  logic signed [PRED_W-1:0] sym_s;
  logic [SYM_W-1:0]         sym;
  logic [TAIL_W-1:0]        sym_x;
  logic [TAIL_W-1:0]        kval;
  logic [K_W-1:0]           k;
  logic [TAIL_W-1:0]        one_k;
  logic [ESUM_W-1:0]        esum;
  logic [ESUM_W-1:0]        equot;

  // row above the first row reads as zero, eneee also beyond the row
  assign north = first_row ? '0 : north_raw;
  assign nw    = first_row ? '0 : nw_pixel;
  assign eneee = (first_row || (SUM_W'(col) + SUM_W'(NEEE_OFFSET) >= SUM_W'(width))) ?
                 '0 : neee_raw;

  // prediction n + w - nw clamped between n and w
  assign lo       = (north < west_pixel) ? north : west_pixel;
  assign hi       = (north < west_pixel) ? west_pixel : north;
  assign pred_raw = $signed(PRED_W'(north)) + $signed(PRED_W'(west_pixel)) -
                    $signed(PRED_W'(nw));

  always_comb begin
    pred = pred_raw;
    if (pred_raw < $signed(PRED_W'(lo))) begin
      pred = $signed(PRED_W'(lo));
    end
    if (pred_raw > $signed(PRED_W'(hi))) begin
      pred = $signed(PRED_W'(hi));
    end
  end

  // zigzag map of the residual
  assign res   = $signed(PRED_W'(pixel)) - pred;
  assign sym_s = (res < 0) ? ((-res) <<< 1) - PRED_W'(1) : (res <<< 1);
  assign sym   = SYM_W'(sym_s);
  assign sym_x = TAIL_W'(sym);

  // k = floor(log2(west_error + 1))
  assign kval = TAIL_W'(west_error) + TAIL_W'(1);

  always_comb begin
    k = '0;
    for (int i = 1; i < TAIL_W; i++) begin
      if (kval[i]) begin
        k = K_W'(i);
      end
    end
  end

  // code: sym >> k zeros, stop bit, k low bits
  assign one_k         = TAIL_W'(1) << k;
  assign job.zeros     = ZERO_W'(sym_x >> k);
  assign job.tail_val  = one_k | (sym_x & (one_k - TAIL_W'(1)));
  assign job.tail_len  = TLEN_W'(k) + TLEN_W'(1);
  assign job.last      = last;

  // running error update, saturated
  assign esum    = (ESUM_W'(west_error) << 1) + ESUM_W'(sym) + ESUM_W'(eneee);
  assign equot   = esum >> 2;
  assign err_new = (equot > ESUM_W'(ERR_MAX)) ? ERR_W'(ERR_MAX) : ERR_W'(equot);

endmodule

### hdl/arpe_packer.sv
// msb-first bit packer into 64-bit words with output register
module arpe_packer import arpe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  arpe_job_t         job,
  output logic              job_ready,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_stream_word,
  output logic              out_last_of_run,
  output logic              out_end_of_stream
);

  typedef enum logic [2:0] {
    P_IDLE  = 3'b001,
    P_CODE  = 3'b010,
    P_FLUSH = 3'b100
  } pk_state_t;

  pk_state_t         pstate_r, pstate_nxt;
  logic [WORD_W-1:0] cache_r, cache_nxt;
  logic [FREE_W-1:0] free_r, free_nxt;
  logic [ZERO_W-1:0] zeros_r, zeros_nxt;
  logic [TAIL_W-1:0] tail_val_r, tail_val_nxt;
  logic [TLEN_W-1:0] tail_len_r, tail_len_nxt;
  logic              last_r, last_nxt;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  logic              out_lor_r;
  logic              out_eos_r;

  logic              can_emit;
  logic              emit;
  logic [WORD_W-1:0] emit_word;
  logic              emit_lor;
  logic              emit_eos;
  logic [FREE_W-1:0] free1;
  logic [FREE_W-1:0] tail_len_f;
  logic [TLEN_W-1:0] spill;
  logic [TOT_W-1:0]  rem_after;

  assign can_emit   = !out_valid_r || !out_stall;
  assign job_ready  = (pstate_r == P_IDLE);
  assign free1      = free_r - FREE_W'(zeros_r);
  assign tail_len_f = FREE_W'(tail_len_r);
  assign spill      = TLEN_W'(tail_len_f - free1);
  assign rem_after  = TOT_W'(zeros_r) - TOT_W'(free_r) + TOT_W'(tail_len_r);

  // one packing step per cycle, held while a word is due and the output is stalled
  always_comb begin
    pstate_nxt   = pstate_r;
    cache_nxt    = cache_r;
    free_nxt     = free_r;
    zeros_nxt    = zeros_r;
    tail_val_nxt = tail_val_r;
    tail_len_nxt = tail_len_r;
    last_nxt     = last_r;
    emit         = 1'b0;
    emit_word    = cache_r;
    emit_lor     = 1'b0;
    emit_eos     = 1'b0;
    unique case (pstate_r)
      P_IDLE: begin
        if (job_valid) begin
          zeros_nxt    = job.zeros;
          tail_val_nxt = job.tail_val;
          tail_len_nxt = job.tail_len;
          last_nxt     = job.last;
          pstate_nxt   = P_CODE;
        end
      end
      P_CODE: begin
        if (ZERO_W'(free_r) <= zeros_r) begin
          // zero run fills the rest of the word
          if (can_emit) begin
            emit      = 1'b1;
            emit_lor  = !last_r && (rem_after < TOT_W'(WORD_W));
            cache_nxt = '0;
            free_nxt  = FREE_W'(WORD_W);
            zeros_nxt = zeros_r - ZERO_W'(free_r);
          end
        end else if (tail_len_f < free1) begin
          // zeros and tail fit without filling the word
          cache_nxt  = cache_r | (WORD_W'(tail_val_r) << (free1 - tail_len_f));
          free_nxt   = free1 - tail_len_f;
          zeros_nxt  = '0;
          pstate_nxt = last_r ? P_FLUSH : P_IDLE;
        end else if (can_emit) begin
          // tail completes the word, remainder goes to a fresh one
          emit         = 1'b1;
          emit_word    = cache_r | WORD_W'(tail_val_r >> spill);
          emit_lor     = !last_r;
          cache_nxt    = '0;
          free_nxt     = FREE_W'(WORD_W);
          zeros_nxt    = '0;
          tail_len_nxt = spill;
          tail_val_nxt = tail_val_r & ((TAIL_W'(1) << spill) - TAIL_W'(1));
          if (spill == '0) begin
            pstate_nxt = last_r ? P_FLUSH : P_IDLE;
          end
        end
      end
      P_FLUSH: begin
        // end of image: emit the current word even when empty
        if (can_emit) begin
          emit       = 1'b1;
          emit_lor   = 1'b1;
          emit_eos   = 1'b1;
          cache_nxt  = '0;
          free_nxt   = FREE_W'(WORD_W);
          pstate_nxt = P_IDLE;
        end
      end
      default: begin
        pstate_nxt = P_IDLE;
      end
    endcase
  end

  // packer control state and bit cache
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pstate_r <= P_IDLE;
      cache_r  <= '0;
      free_r   <= FREE_W'(WORD_W);
    end else begin
      pstate_r <= pstate_nxt;
      cache_r  <= cache_nxt;
      free_r   <= free_nxt;
    end
  end

  // code being packed
  always_ff @(posedge clk) begin
    zeros_r    <= zeros_nxt;
    tail_val_r <= tail_val_nxt;
    tail_len_r <= tail_len_nxt;
    last_r     <= last_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word_r <= emit_word;
      out_lor_r  <= emit_lor;
      out_eos_r  <= emit_eos;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_stream_word   = out_word_r;
  assign out_last_of_run   = out_lor_r;
  assign out_end_of_stream = out_eos_r;

endmodule

### verif/tb_adaptive_rice_pixel_encoder.sv
// testbench for the adaptive rice pixel encoder: predicted code words against the block
`timescale 1ns / 100ps

module tb_adaptive_rice_pixel_encoder;
  import arpe_pkg::*;

  localparam int ROW_MAX = 4096;
  localparam int PIX_W   = 10;
  localparam int SETTLE  = 12;      // cycles after the last word before a register write
  localparam int HOLD    = 400;     // long receiver hold-off
  localparam int LIMIT   = 500000;  // cycle budget of the whole run

  // one expected word of the packed stream
  typedef struct {
    logic [WORD_W-1:0] word;
    logic              last_run;
    logic              eos;
  } coded_word_t;

  // predictor of the encoder and store of words still owed by it
  class rice_scoreboard;
    logic [PIX_W-1:0] above_pix [ROW_MAX];
    logic [10:0]      above_err [ROW_MAX];
    int unsigned      width_reg;
    int unsigned      west_pix, nw_pix, west_err, col, free_cnt;
    logic [63:0]      cache;
    bit               top_row;
    coded_word_t      due_q[$];
    int               errors, words_seen, pixels_seen, images_seen;

    function new();
      foreach (above_pix[i]) above_pix[i] = '0;
      foreach (above_err[i]) above_err[i] = '0;
      width_reg = ROW_MAX;
      west_pix = 0;
      nw_pix = 0;
      west_err = 0;
      col = 0;
      cache = '0;
      free_cnt = 64;
      top_row = 1;
      errors = 0;
      words_seen = 0;
      pixels_seen = 0;
      images_seen = 0;
    endfunction

    function void set_width(logic [CFG_W-1:0] w);
      width_reg = 32'(w);
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // one code bit into the open word, msb first
    function void push_bit(bit b);
      cache[free_cnt-1] = b;
      free_cnt--;
      if (free_cnt == 0) begin
        due_q.push_back('{cache, 1'b0, 1'b0});
        cache = '0;
        free_cnt = 64;
      end
    endfunction

    // code one accepted pixel transaction
    function void note_pixel(logic [PIX_W-1:0] pix, bit last);
      int unsigned w, c, n, nw, ne3, lo, hi, sym, k, tmp, e_new;
      int pred, res;
      int q_start;
      q_start = due_q.size();
      pixels_seen++;
      w = width_reg;
      if (w < 1) w = 1;
      if (w > ROW_MAX) w = ROW_MAX;
      c = col % ROW_MAX;
      n = top_row ? 0 : above_pix[c];
      nw = top_row ? 0 : nw_pix;
      ne3 = (top_row || c + NEEE_OFFSET >= w) ? 0 : above_err[c + NEEE_OFFSET];
      // median prediction, clamped between north and west
      lo = (n < west_pix) ? n : west_pix;
      hi = (n < west_pix) ? west_pix : n;
      pred = int'(n) + int'(west_pix) - int'(nw);
      if (pred < int'(lo)) pred = lo;
      if (pred > int'(hi)) pred = hi;
      res = int'(pix) - pred;
      sym = (res < 0) ? (2 * (-res) - 1) : (2 * res);
      // rice parameter from the west error
      k = 0;
      tmp = west_err + 1;
      while (tmp > 1) begin
        tmp >>= 1;
        k++;
      end
      for (int i = 0; i < int'(sym >> k); i++) push_bit(1'b0);
      push_bit(1'b1);
      for (int i = int'(k) - 1; i >= 0; i--) push_bit(sym[i]);
      // error update and row memories
      e_new = (2 * west_err + sym + ne3) >> 2;
      if (e_new > 2047) e_new = 2047;
      above_pix[c] = pix;
      above_err[c] = 11'(e_new);
      nw_pix = n;
      west_pix = pix;
      west_err = e_new;
      col = c + 1;
      if (col >= w || last) begin
        col = 0;
        west_pix = 0;
        west_err = 0;
        nw_pix = 0;
        top_row = 0;
      end
      // image end flushes the open word, empty or not
      if (last) begin
        due_q.push_back('{cache, 1'b0, 1'b1});
        cache = '0;
        free_cnt = 64;
        top_row = 1;
        images_seen++;
      end
      if (due_q.size() > q_start) due_q[due_q.size()-1].last_run = 1'b1;
    endfunction

    // compare one output transaction with the oldest expected word
    function void check_word(logic [WORD_W-1:0] word, logic lr, logic eos);
      coded_word_t exp_w;
      words_seen++;
      if (due_q.size() == 0) begin
        $error("stream_word: no word expected, got %h", word);
        errors++;
        return;
      end
      exp_w = due_q.pop_front();
      if (word !== exp_w.word) begin
        $error("stream_word: expected %h, actual %h", exp_w.word, word);
        errors++;
      end
      if (lr !== exp_w.last_run) begin
        $error("last_of_run: expected %0b, actual %0b", exp_w.last_run, lr);
        errors++;
      end
      if (eos !== exp_w.eos) begin
        $error("end_of_stream: expected %0b, actual %0b", exp_w.eos, eos);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_W-1:0]     cfg_image_width;
  logic                 in_valid;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_pixel_value;
  logic                 in_last_pixel;
  logic                 out_valid;
  logic                 out_stall;
  logic [WORD_W-1:0]    out_stream_word;
  logic                 out_last_of_run;
  logic                 out_end_of_stream;

  rice_scoreboard sb;
  bit             hold_req;
  int             cycles;
  int             widths_set;

  adaptive_rice_pixel_encoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_image_width   (cfg_image_width),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pixel_value    (in_pixel_value),
    .in_last_pixel     (in_last_pixel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_stream_word   (out_stream_word),
    .out_last_of_run   (out_last_of_run),
    .out_end_of_stream (out_end_of_stream)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // accepted transactions on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_pixel(in_pixel_value, in_last_pixel);
      if (out_valid && !out_stall)
        sb.check_word(out_stream_word, out_last_of_run, out_end_of_stream);
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int mode;
    int cnt;
    mode = 0;
    cnt = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD) @(negedge clk);
        hold_req = 0;
        out_stall <= 1'b0;
      end else begin
        cnt++;
        if (cnt % 50 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ((cnt % 16) < 10);
          default: out_stall <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  // next sample of a synthetic image
  function automatic logic [PIX_W-1:0] next_sample(int mode, logic [PIX_W-1:0] prev);
    int v;
    case (mode)
      0: v = $urandom_range(0, 1023);
      1: v = int'(prev) + int'($urandom_range(0, 16)) - 8;
      2: v = $urandom_range(0, 1) ? 1023 : 0;
      default: v = prev;
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return PIX_W'(v);
  endfunction

  // offer one pixel and wait until it is taken
  task automatic send_pixel(input logic [PIX_W-1:0] p, input bit l);
    @(negedge clk);
    in_valid <= 1'b1;
    in_pixel_value <= p;
    in_last_pixel <= l;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering and wait for every owed word, then let the pipe settle
  task automatic finish_phase();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_width(input logic [CFG_W-1:0] w);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_image_width <= w;
    sb.set_width(w);
    widths_set++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // random images sent in bursts with gaps
  task automatic run_phase(input int count, input int mode);
    logic [PIX_W-1:0] p;
    bit l;
    int burst;
    int gap;
    p = PIX_W'($urandom_range(0, 1023));
    burst = $urandom_range(1, 12);
    for (int i = 0; i < count; i++) begin
      p = next_sample(mode, p);
      if ($urandom_range(0, 9) == 0) p = next_sample(0, p);
      l = ($urandom_range(0, 17) == 0) || (i == count - 1 && $urandom_range(0, 1) == 1);
      send_pixel(p, l);
      if (l && $urandom_range(0, 1) == 1) mode = $urandom_range(0, 3);
      burst--;
      if (burst == 0) begin
        gap = $urandom_range(1, 7);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
        burst = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] w;
    sb = new();
    hold_req = 0;
    cycles = 0;
    widths_set = 0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_image_width = '0;
    in_valid = 1'b0;
    in_pixel_value = '0;
    in_last_pixel = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // reset width, first row of the first image
    send_pixel(10'd0, 1'b0);
    send_pixel(10'd1023, 1'b0);
    send_pixel(10'd512, 1'b1);
    finish_phase();

    // one pixel per row: exactly full word then an empty flush, then longest zero runs
    write_width(13'd1);
    send_pixel(10'd31, 1'b0);
    send_pixel(10'd31, 1'b1);
    send_pixel(10'd0, 1'b0);
    send_pixel(10'd1023, 1'b0);
    send_pixel(10'd0, 1'b1);
    finish_phase();

    // narrow rows, previous row and north-east error in use
    write_width(13'd4);
    send_pixel(10'd1023, 1'b0);
    send_pixel(10'd0, 1'b0);
    send_pixel(10'd1023, 1'b0);
    send_pixel(10'd0, 1'b0);
    send_pixel(10'd0, 1'b0);
    send_pixel(10'd1023, 1'b0);
    send_pixel(10'd600, 1'b0);
    send_pixel(10'd400, 1'b1);
    finish_phase();

    // register extremes, clamped to the allowed width range
    write_width(13'h1fff);
    send_pixel(10'd5, 1'b0);
    send_pixel(10'd700, 1'b1);
    finish_phase();
    write_width(13'd0);
    send_pixel(10'd3, 1'b0);
    send_pixel(10'd9, 1'b1);
    finish_phase();

    // width shrinks below the current column in mid-row
    write_width(13'd8);
    send_pixel(10'd100, 1'b0);
    send_pixel(10'd110, 1'b0);
    send_pixel(10'd120, 1'b0);
    send_pixel(10'd130, 1'b0);
    send_pixel(10'd140, 1'b0);
    finish_phase();
    write_width(13'd3);
    send_pixel(10'd150, 1'b0);
    send_pixel(10'd160, 1'b1);
    finish_phase();

    // random phases, each at its own width
    for (int ph = 0; ph < 9; ph++) begin
      case ($urandom_range(0, 7))
        0: w = CFG_W'($urandom_range(0, 8191));
        1: w = 13'd4096;
        default: w = CFG_W'($urandom_range(1, 12));
      endcase
      write_width(w);
      if (ph == 2) hold_req = 1;
      run_phase($urandom_range(18, 28), (ph == 2) ? 0 : $urandom_range(0, 3));
      finish_phase();
    end

    $display("covered %0d pixels in %0d images over %0d width settings, %0d words checked",
             sb.pixels_seen, sb.images_seen, widths_set, sb.words_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
